// ===== src/lfu_pkg.sv =====
// shared constants and types for the lfu tag store
`timescale 1ns / 1ps

package lfu_pkg;

  // default configuration
  localparam int ENTRIES_DEF    = 5;
  localparam int KEY_BITS_DEF   = 8;
  localparam int COUNT_BITS_DEF = 16;

  // port field widths
  localparam int LOOKUP_KEY_W  = 8;
  localparam int SLOT_W        = 3;
  localparam int EVICTED_KEY_W = 8;
  localparam int USE_AFTER_W   = 16;

  // commands from controller to datapath
  typedef struct packed {
    logic load_key;
    logic commit;
  } cmd_t;

endpackage

// ===== src/lfu_replacement_cache_tags_core.sv =====
// top level of the lfu tag store: controller and datapath
`timescale 1ns / 1ps

//  channel  | ports                                        | direction
//  ---------+----------------------------------------------+----------
//  request  | in_valid, in_stall, in_lookup_key            | in
//  result   | out_valid, out_stall, out_hit, out_slot,     | out
//           | out_evicted_valid, out_evicted_key,          |
//           | out_use_after                                |
//
// a request is handled in order: capture, then match, victim tree and write-back
// the victim search is a pairwise compare tree over all entries in the commit cycle
// reset clears valid bits and handshake state; counts of empty entries read as zero
// a stalled result holds the request in its commit cycle; in_stall stays high meanwhile

module lfu_replacement_cache_tags_core #(
  parameter int ENTRIES    = lfu_pkg::ENTRIES_DEF,
  parameter int KEY_BITS   = lfu_pkg::KEY_BITS_DEF,
  parameter int COUNT_BITS = lfu_pkg::COUNT_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [lfu_pkg::LOOKUP_KEY_W-1:0]   in_lookup_key,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_hit,
  output logic [lfu_pkg::SLOT_W-1:0]         out_slot,
  output logic                               out_evicted_valid,
  output logic [lfu_pkg::EVICTED_KEY_W-1:0]  out_evicted_key,
  output logic [lfu_pkg::USE_AFTER_W-1:0]    out_use_after
);

  lfu_pkg::cmd_t cmd;

  lfu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  lfu_datapath #(
    .ENTRIES    (ENTRIES),
    .KEY_BITS   (KEY_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_lookup_key     (in_lookup_key),
    .out_hit           (out_hit),
    .out_slot          (out_slot),
    .out_evicted_valid (out_evicted_valid),
    .out_evicted_key   (out_evicted_key),
    .out_use_after     (out_use_after)
  );

endmodule

// ===== src/lfu_ctrl.sv =====
// controller for the lfu tag store: request sequencing and result handshake
`timescale 1ns / 1ps

module lfu_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  output lfu_pkg::cmd_t cmd
);

  typedef enum logic {
    S_IDLE,
    S_BUSY
  } state_t;

  state_t state_r;
  logic   out_valid_r;
  logic   out_free;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  // result register can take a new request when empty or draining now
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    cmd = '0;
    case (state_r)
      S_IDLE: cmd.load_key = in_valid;
      S_BUSY: cmd.commit   = out_free;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            state_r <= S_BUSY;
          end
        end
        S_BUSY: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== src/lfu_datapath.sv =====
// datapath for the lfu tag store: entries, match, victim search, result register
`timescale 1ns / 1ps

module lfu_datapath #(
  parameter int ENTRIES    = lfu_pkg::ENTRIES_DEF,
  parameter int KEY_BITS   = lfu_pkg::KEY_BITS_DEF,
  parameter int COUNT_BITS = lfu_pkg::COUNT_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  lfu_pkg::cmd_t                      cmd,
  input  logic [lfu_pkg::LOOKUP_KEY_W-1:0]   in_lookup_key,
  output logic                               out_hit,
  output logic [lfu_pkg::SLOT_W-1:0]         out_slot,
  output logic                               out_evicted_valid,
  output logic [lfu_pkg::EVICTED_KEY_W-1:0]  out_evicted_key,
  output logic [lfu_pkg::USE_AFTER_W-1:0]    out_use_after
);

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int PAD_N = 1 << IDX_W;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  logic [KEY_BITS-1:0]   key_r;
  logic [KEY_BITS-1:0]   tag_r   [ENTRIES];
  logic [COUNT_BITS-1:0] cnt_r   [ENTRIES];
  logic [ENTRIES-1:0]    valid_r;

  logic                  hit;
  logic [IDX_W-1:0]      hit_idx;
  logic [IDX_W-1:0]      vic_idx;
  logic [IDX_W-1:0]      sel_idx;
  logic [KEY_BITS-1:0]   sel_tag;
  logic [COUNT_BITS-1:0] sel_cnt;
  logic                  sel_valid;
  logic [COUNT_BITS-1:0] inc_cnt;
  logic [COUNT_BITS-1:0] use_nxt;

  // min tree operands; top bit marks padding so it never wins
  logic [COUNT_BITS:0]   tree_cnt [PAD_N];
  logic [IDX_W-1:0]      tree_idx [PAD_N];

  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (valid_r[i] && (tag_r[i] == key_r)) begin
        hit     = 1'b1;
        hit_idx = IDX_W'(i);
      end
    end
  end

  // pairwise minimum, left side kept on ties for lowest index
  always_comb begin
    for (int i = 0; i < PAD_N; i++) begin
      tree_idx[i] = IDX_W'(i);
      if (i < ENTRIES) begin
        tree_cnt[i] = {1'b0, (valid_r[i] ? cnt_r[i] : '0)};
      end else begin
        tree_cnt[i] = {1'b1, COUNT_MAX};
      end
    end
    for (int l = 0; l < IDX_W; l++) begin
      for (int j = 0; j < (PAD_N >> (l + 1)); j++) begin
        if (tree_cnt[2*j+1] < tree_cnt[2*j]) begin
          tree_cnt[j] = tree_cnt[2*j+1];
          tree_idx[j] = tree_idx[2*j+1];
        end else begin
          tree_cnt[j] = tree_cnt[2*j];
          tree_idx[j] = tree_idx[2*j];
        end
      end
    end
    vic_idx = tree_idx[0];
  end

  assign sel_idx = hit ? hit_idx : vic_idx;

  always_comb begin
    sel_tag   = '0;
    sel_cnt   = '0;
    sel_valid = 1'b0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (IDX_W'(i) == sel_idx) begin
        sel_tag   = tag_r[i];
        sel_cnt   = cnt_r[i];
        sel_valid = valid_r[i];
      end
    end
  end

  assign inc_cnt = (sel_cnt == COUNT_MAX) ? sel_cnt : sel_cnt + COUNT_BITS'(1);
  assign use_nxt = hit ? inc_cnt : COUNT_BITS'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd.commit && !hit) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (IDX_W'(i) == vic_idx) begin
          valid_r[i] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_key) begin
      key_r <= KEY_BITS'(in_lookup_key);
    end
    if (cmd.commit) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (IDX_W'(i) == sel_idx) begin
          cnt_r[i] <= use_nxt;
          if (!hit) begin
            tag_r[i] <= key_r;
          end
        end
      end
      out_hit           <= hit;
      out_slot          <= lfu_pkg::SLOT_W'(sel_idx);
      out_evicted_valid <= !hit && sel_valid;
      out_evicted_key   <= (!hit && sel_valid) ?
                           lfu_pkg::EVICTED_KEY_W'(sel_tag) : '0;
      out_use_after     <= lfu_pkg::USE_AFTER_W'(use_nxt);
    end
  end

endmodule
